// ----- sv/sgp_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the scatter gather segment pairer
package sgp_pkg;

    localparam int SGP_MAX_PARTS = 16;
    localparam int ADDR_W        = 32;
    localparam logic [ADDR_W-1:0] USER_LIMIT_RST = 32'h8000_0000;

    // request command codes, code 3 is unused
    typedef enum logic [1:0] {
        CMD_LOAD_DST = 2'd0,
        CMD_LOAD_SRC = 2'd1,
        CMD_START    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_EMIT,
        ST_REFILL
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] len;
    } t_desc;

    typedef struct packed {
        logic [ADDR_W-1:0] out_dst_addr;
        logic [ADDR_W-1:0] out_src_addr;
        logic [ADDR_W-1:0] copy_length;
        logic              to_user;
        logic              fault;
        logic              last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load_dst;
        logic load_src;
        logic start;
        logic init;
        logic emit;
        logic refill;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_sts;

endpackage

// ----- sv/sgp_if.sv -----
`timescale 1ns / 1ps
// request, result and configuration channel interfaces
interface sgp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] base_addr;
    logic [31:0] seg_length;
    logic [31:0] dst_offset;
    logic [31:0] src_offset;

    modport source (output valid, command, base_addr, seg_length, dst_offset, src_offset,
                    input ready);
    modport sink   (input valid, command, base_addr, seg_length, dst_offset, src_offset,
                    output ready);
endinterface

interface sgp_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_dst_addr;
    logic [31:0] out_src_addr;
    logic [31:0] copy_length;
    logic        to_user;
    logic        fault;
    logic        last;

    modport source (output valid, out_dst_addr, out_src_addr, copy_length, to_user, fault,
                    last, input ready);
    modport sink   (input valid, out_dst_addr, out_src_addr, copy_length, to_user, fault,
                    last, output ready);
endinterface

interface sgp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] wdata;

    modport source (output valid, wdata, input ready);
    modport sink   (input valid, wdata, output ready);
endinterface

// ----- sv/sgp_ctrl.sv -----
`timescale 1ns / 1ps
// control state machine for the segment pairer
module sgp_ctrl
    import sgp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic [1:0] i_command,
    output logic       o_req_ready,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_idle
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid && i_command == CMD_START) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.last ? ST_IDLE : ST_REFILL;
                end
            end
            ST_REFILL: begin
                n_state = ST_EMIT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    unique case (i_command)
                        CMD_LOAD_DST: o_cmd.load_dst = 1'b1;
                        CMD_LOAD_SRC: o_cmd.load_src = 1'b1;
                        CMD_START:    o_cmd.start    = 1'b1;
                        default:      o_cmd          = '0;
                    endcase
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            ST_REFILL: begin
                o_cmd.refill = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

// ----- sv/sgp_dp.sv -----
`timescale 1ns / 1ps
// descriptor stores, walk registers and result register
module sgp_dp
    import sgp_pkg::*;
#(
    parameter int MAX_PARTS = SGP_MAX_PARTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [ADDR_W-1:0] i_base_addr,
    input  logic [ADDR_W-1:0] i_seg_length,
    input  logic [ADDR_W-1:0] i_dst_offset,
    input  logic [ADDR_W-1:0] i_src_offset,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_res              o_res
);

    localparam int CNT_W = $clog2(MAX_PARTS + 1);
    localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

    t_desc dst_mem [MAX_PARTS];
    t_desc src_mem [MAX_PARTS];

    logic [ADDR_W-1:0] r_limit;
    logic [CNT_W-1:0]  r_dst_cnt, r_src_cnt;
    logic [IDX_W-1:0]  r_di, r_si, n_di, n_si;
    t_desc             r_dq, r_sq;
    logic [ADDR_W-1:0] r_doff, r_soff;
    logic [ADDR_W-1:0] r_daddr, r_dlen, r_saddr, r_slen;
    logic              r_fault;
    logic              r_adv_d, r_adv_s;
    logic              r_out_valid;
    t_res              r_res;

    logic              s_lt, d_lt, done_d, done_s, done, last;
    logic              adv_d, adv_s, out_free;
    logic [ADDR_W-1:0] seg;
    logic [CNT_W:0]    di_inc, si_inc;

    // walk decision
    assign s_lt   = r_slen < r_dlen;
    assign d_lt   = r_dlen < r_slen;
    assign seg    = s_lt ? r_slen : r_dlen;
    assign adv_s  = s_lt || !d_lt;
    assign adv_d  = d_lt || !s_lt;
    assign di_inc = (CNT_W+1)'(r_di) + (CNT_W+1)'(1);
    assign si_inc = (CNT_W+1)'(r_si) + (CNT_W+1)'(1);
    assign done_d = di_inc >= {1'b0, r_dst_cnt};
    assign done_s = si_inc >= {1'b0, r_src_cnt};
    assign done   = (adv_d && done_d) || (adv_s && done_s);
    assign last   = r_fault || done;

    assign out_free       = !r_out_valid || i_res_ready;
    assign o_sts.out_free = out_free;
    assign o_sts.last     = last;

    always_comb begin
        n_di = r_di;
        n_si = r_si;
        if (i_cmd.start) begin
            n_di = '0;
            n_si = '0;
        end else if (i_cmd.emit && !last) begin
            if (adv_d) n_di = di_inc[IDX_W-1:0];
            if (adv_s) n_si = si_inc[IDX_W-1:0];
        end
    end

    // descriptor stores, registered read at the next index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_dst && r_dst_cnt < CNT_W'(MAX_PARTS)) begin
            dst_mem[r_dst_cnt[IDX_W-1:0]] <= '{base: i_base_addr, len: i_seg_length};
        end
        if (i_cmd.load_src && r_src_cnt < CNT_W'(MAX_PARTS)) begin
            src_mem[r_src_cnt[IDX_W-1:0]] <= '{base: i_base_addr, len: i_seg_length};
        end
        r_dq <= dst_mem[n_di];
        r_sq <= src_mem[n_si];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= USER_LIMIT_RST;
            r_dst_cnt   <= '0;
            r_src_cnt   <= '0;
            r_di        <= '0;
            r_si        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_di <= n_di;
            r_si <= n_si;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (i_cmd.load_dst && r_dst_cnt < CNT_W'(MAX_PARTS)) begin
                r_dst_cnt <= r_dst_cnt + CNT_W'(1);
            end
            if (i_cmd.load_src && r_src_cnt < CNT_W'(MAX_PARTS)) begin
                r_src_cnt <= r_src_cnt + CNT_W'(1);
            end
            if (i_cmd.emit && last) begin
                r_dst_cnt <= '0;
                r_src_cnt <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk registers and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_doff <= i_dst_offset;
            r_soff <= i_src_offset;
        end
        if (i_cmd.init) begin
            r_fault <= (r_dst_cnt == '0) || (r_src_cnt == '0) ||
                       (r_doff > r_dq.len) || (r_soff > r_sq.len);
            r_daddr <= r_dq.base + r_doff;
            r_dlen  <= r_dq.len - r_doff;
            r_saddr <= r_sq.base + r_soff;
            r_slen  <= r_sq.len - r_soff;
        end
        if (i_cmd.emit) begin
            if (r_fault) begin
                r_res <= '{out_dst_addr: '0, out_src_addr: '0, copy_length: '0,
                           to_user: 1'b0, fault: 1'b1, last: 1'b1};
            end else begin
                r_res <= '{out_dst_addr: r_daddr, out_src_addr: r_saddr, copy_length: seg,
                           to_user: r_daddr < r_limit, fault: 1'b0, last: done};
            end
            r_adv_d <= adv_d;
            r_adv_s <= adv_s;
            if (!adv_d) begin
                r_daddr <= r_daddr + seg;
                r_dlen  <= r_dlen - seg;
            end
            if (!adv_s) begin
                r_saddr <= r_saddr + seg;
                r_slen  <= r_slen - seg;
            end
        end
        if (i_cmd.refill) begin
            if (r_adv_d) begin
                r_daddr <= r_dq.base;
                r_dlen  <= r_dq.len;
            end
            if (r_adv_s) begin
                r_saddr <= r_sq.base;
                r_slen  <= r_sq.len;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

// ----- sv/scatter_gather_segment_pairer_top.sv -----
`timescale 1ns / 1ps
// top level of the scatter gather segment pairer
//
//  channel  | dir | handshake        | carries
//  ---------+-----+------------------+-----------------------------------------------
//  i_req    | in  | valid / ready    | command, base_addr, seg_length, offsets
//  o_res    | out | valid / ready    | out_dst_addr, out_src_addr, copy_length, flags
//  i_cfg    | in  | valid / ready    | user_space_limit write data
//
//  a load request is written to its store when accepted; requests are accepted while idle
//  a start request reads the first descriptors as it is accepted, then applies the
//  offsets, then alternates emit with a reload of the descriptor that ran out
//  from the single read port of its store, until the last result is emitted
//  a stalled result holds the walk in its emit step; reset is synchronous,
//  active low, and clears counts, limit and the result valid
module scatter_gather_segment_pairer_top
    import sgp_pkg::*;
#(
    parameter int MAX_PARTS = SGP_MAX_PARTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sgp_req_if.sink      i_req,
    sgp_res_if.source    o_res,
    sgp_cfg_if.sink      i_cfg
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_res    res;
    logic    res_valid;
    logic    ctrl_idle;

    // limit register is always writable, idle use is the caller's duty
    assign i_cfg.ready = 1'b1;

    // controller sequences loads, the start, and the emit/refill walk
    sgp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_command   (i_req.command),
        .o_req_ready (i_req.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .o_idle      (ctrl_idle)
    );

    // datapath holds descriptor stores, walk position and the result register
    sgp_dp #(
        .MAX_PARTS (MAX_PARTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_base_addr  (i_req.base_addr),
        .i_seg_length (i_req.seg_length),
        .i_dst_offset (i_req.dst_offset),
        .i_src_offset (i_req.src_offset),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_wdata  (i_cfg.wdata),
        .o_res_valid  (res_valid),
        .i_res_ready  (o_res.ready),
        .o_res        (res)
    );

    // result channel straight from the output register
    assign o_res.valid        = res_valid;
    assign o_res.out_dst_addr = res.out_dst_addr;
    assign o_res.out_src_addr = res.out_src_addr;
    assign o_res.copy_length  = res.copy_length;
    assign o_res.to_user      = res.to_user;
    assign o_res.fault        = res.fault;
    assign o_res.last         = res.last;

`ifndef NO_ASSERTIONS
    // a result is only written when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> dp_sts.out_free)
        else $error("emit while result register full");

    // an error result always ends the start
    a_fault_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.fault) |-> o_res.last)
        else $error("fault result without last");

    // accepted start blocks new requests on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.command == CMD_START) |=> !i_req.ready)
        else $error("request accepted during walk");

    // the final result of a walk returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.emit && dp_sts.last) |=> ctrl_idle)
        else $error("walk did not finish after last result");
`endif

endmodule
